>>> hw/rtl/mbps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 9;   // pattern_length register
  localparam int RANGE_W    = 16;  // range_start / range_end registers
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int REQ_W      = 2;
  localparam int IN_DATA_W  = 24;  // entry_index, value_byte, entry_care
  localparam int OUT_DATA_W = 24;  // match_found, match_address
  localparam int OUT_ADDR_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 2'd0,
    CFG_RANGE_START    = 2'd1,
    CFG_RANGE_END      = 2'd2
  } cfg_reg_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_BEGIN = 2'd1,
    REQ_BYTE  = 2'd2
  } req_type_t;

  // Broadcast control for the cell row.
  typedef struct packed {
    logic clear;   // begin of scan: drop window and partial matches
    logic shift;   // new memory byte enters the row
    logic replay;  // rotate the stored window back through the row
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/mbps_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_cell
// One matcher cell: a pattern entry with its care bit, one window byte and
// the partial match of the pattern prefix that ends at this cell.
// ----------------------------------------------------------------------------
module mbps_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire mbps_pkg::cell_ctl_t         ctl,
  input  wire logic                        load_en,
  input  wire logic [mbps_pkg::BYTE_W-1:0] load_byte,
  input  wire logic                        load_care,
  input  wire logic [mbps_pkg::BYTE_W-1:0] feed_byte,
  input  wire logic                        feed_vld,
  input  wire logic [mbps_pkg::BYTE_W-1:0] up_byte,
  input  wire logic                        up_vld,
  input  wire logic                        up_pm,
  output logic      [mbps_pkg::BYTE_W-1:0] win_byte,
  output logic                             win_vld,
  output logic                             pm,
  output logic                             pm_next
);
  import mbps_pkg::*;

  logic [BYTE_W-1:0] pat_byte;
  logic              care;
  logic              step;

  assign step    = ctl.shift | ctl.replay;
  assign pm_next = feed_vld & up_pm & (~care | (feed_byte == pat_byte));

  always_ff @(posedge clk) begin
    if (load_en) begin
      pat_byte <= load_byte;
    end
    if (step) begin
      win_byte <= up_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      care    <= 1'b1;
      win_vld <= 1'b0;
      pm      <= 1'b0;
    end else begin
      if (load_en) begin
        care <= load_care;
      end
      if (ctl.clear) begin
        win_vld <= 1'b0;
        pm      <= 1'b0;
      end else if (step) begin
        win_vld <= up_vld;
        pm      <= pm_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/mbps_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_chain
// Row of matcher cells. Window bytes move one cell per step; in replay the
// oldest byte wraps around to the head of the row.
// ----------------------------------------------------------------------------
module mbps_chain #(
  parameter int NUM_CELLS = 256,
  parameter int SEL_W     = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire mbps_pkg::cell_ctl_t         ctl,
  input  wire logic [mbps_pkg::BYTE_W-1:0] in_byte,
  input  wire logic                        load_go,
  input  wire logic [mbps_pkg::BYTE_W-1:0] load_index,
  input  wire logic [mbps_pkg::BYTE_W-1:0] load_byte,
  input  wire logic                        load_care,
  input  wire logic [SEL_W-1:0]            sel,
  output logic                             match_next
);
  import mbps_pkg::*;

  logic [BYTE_W-1:0] win_byte [NUM_CELLS];
  logic              win_vld  [NUM_CELLS];
  logic              pm       [NUM_CELLS];
  logic              pm_next  [NUM_CELLS];
  logic [BYTE_W-1:0] feed_byte;
  logic              feed_vld;

  // Replay feeds the oldest stored byte; a scan step feeds the new byte.
  assign feed_byte = ctl.replay ? win_byte[NUM_CELLS-1] : in_byte;
  assign feed_vld  = ctl.replay ? win_vld[NUM_CELLS-1]  : 1'b1;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    logic [BYTE_W-1:0] up_byte;
    logic              up_vld;
    logic              up_pm;
    logic              load_en;

    if (k == 0) begin : g_head
      assign up_byte = feed_byte;
      assign up_vld  = feed_vld;
      assign up_pm   = 1'b1;
    end else begin : g_body
      assign up_byte = win_byte[k-1];
      assign up_vld  = win_vld[k-1];
      assign up_pm   = pm[k-1];
    end

    assign load_en = load_go & (32'(load_index) == k);

    mbps_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .load_en   (load_en),
      .load_byte (load_byte),
      .load_care (load_care),
      .feed_byte (feed_byte),
      .feed_vld  (feed_vld),
      .up_byte   (up_byte),
      .up_vld    (up_vld),
      .up_pm     (up_pm),
      .win_byte  (win_byte[k]),
      .win_vld   (win_vld[k]),
      .pm        (pm[k]),
      .pm_next   (pm_next[k])
    );
  end

  assign match_next = pm_next[sel];

endmodule
`default_nettype wire

>>> hw/rtl/masked_byte_pattern_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan
// Masked byte pattern search over an address-ordered byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_t* (tuser = request type). A load request writes one
//   pattern entry and its care bit, a begin request starts a scan at the lower
//   range bound, a memory byte request feeds the next byte of the range.
//   Every memory byte taken during a scan gives one result on m_t*: tdata
//   holds match_found and the match start address, tlast marks the byte at
//   the higher range bound, which also ends the scan.
//   The result is registered and shows in the cycle after the request is taken.
//   Throughput: one request per cycle while s_tready is high, set by the
//   cell row, where each cell compares the broadcast byte against its entry
//   and extends the partial match of its neighbor in the same cycle.
//   A load request during a running scan rewrites an entry that partial
//   matches already used: the row then replays its stored window, one byte a
//   cycle, through a full rotation of the row with s_tready low.
//   When the receiver stalls, the result register holds and s_tready drops
//   until it drains. Reset (rst, synchronous) restores the register defaults,
//   sets every care bit and stops any scan; pattern bytes keep no reset.
//   Configuration writes on cfg_* take effect at the next request.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan #(
  parameter int MAX_PATTERN = 256,
  parameter int ADDR_BITS   = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data,
  // requests
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [7:0] entry_index, [15:8] value_byte, [16] entry_care, [23:17] zero
  input  wire logic [mbps_pkg::IN_DATA_W-1:0]  s_tdata,
  // [1:0] req_type
  input  wire logic [mbps_pkg::REQ_W-1:0]      s_tuser,
  // results
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [0] match_found, [16:1] match_address, [23:17] zero
  output logic      [mbps_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                                 m_tlast   // range_done
);
  import mbps_pkg::*;

  localparam int SEL_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
  localparam int USED_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  // configuration registers
  logic [LEN_W-1:0]   pattern_length;
  logic [RANGE_W-1:0] range_start;
  logic [RANGE_W-1:0] range_end;

  // scan state
  logic                 scan_active;
  logic [ADDR_BITS-1:0] current_address;
  logic [CNT_W-1:0]     replay_count;
  logic                 replay_busy;

  // request decode
  logic                  accept;
  logic [BYTE_W-1:0]     entry_index;
  logic [BYTE_W-1:0]     value_byte;
  logic                  entry_care;
  logic                  load_go;
  logic                  begin_go;
  logic                  byte_go;

  // per-byte evaluation
  logic [USED_W-1:0]     used_len;
  logic [ADDR_BITS-1:0]  bound_a;
  logic [ADDR_BITS-1:0]  bound_b;
  logic [ADDR_BITS-1:0]  low_bound;
  logic [ADDR_BITS-1:0]  high_bound;
  logic [ADDR_BITS-1:0]  start_addr;
  logic                  range_done;
  logic                  match_next;
  logic [OUT_ADDR_W-1:0] match_address;
  cell_ctl_t             ctl;

  assign entry_index = s_tdata[7:0];
  assign value_byte  = s_tdata[15:8];
  assign entry_care  = s_tdata[16];

  // Hold requests while the result waits or the row replays.
  assign replay_busy = (replay_count != '0);
  assign s_tready    = ~replay_busy & (~m_tvalid | m_tready);
  assign accept      = s_tvalid & s_tready;

  assign load_go  = accept & (s_tuser == REQ_LOAD) & (32'(entry_index) < MAX_PATTERN);
  assign begin_go = accept & (s_tuser == REQ_BEGIN);
  assign byte_go  = accept & (s_tuser == REQ_BYTE) & scan_active;

  assign ctl.clear  = begin_go;
  assign ctl.shift  = byte_go;
  assign ctl.replay = replay_busy;

  // Clamp the length: zero counts as one, longer than the row as the row.
  always_comb begin
    if (pattern_length == '0) begin
      used_len = USED_W'(1);
    end else if (USED_W'(pattern_length) > USED_W'(MAX_PATTERN)) begin
      used_len = USED_W'(MAX_PATTERN);
    end else begin
      used_len = USED_W'(pattern_length);
    end
  end

  assign bound_a    = ADDR_BITS'(range_start);
  assign bound_b    = ADDR_BITS'(range_end);
  assign low_bound  = (bound_a < bound_b) ? bound_a : bound_b;
  assign high_bound = (bound_a < bound_b) ? bound_b : bound_a;
  assign range_done = (current_address >= high_bound);
  assign start_addr = current_address - ADDR_BITS'(used_len - USED_W'(1));

  // A match needs the full window inside the range; partial matches are
  // cleared at begin, so a short run never reaches the selected cell.
  assign match_address = match_next ? OUT_ADDR_W'(start_addr) : '0;

  mbps_chain #(
    .NUM_CELLS (MAX_PATTERN),
    .SEL_W     (SEL_W)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .in_byte    (value_byte),
    .load_go    (load_go),
    .load_index (entry_index),
    .load_byte  (value_byte),
    .load_care  (entry_care),
    .sel        (SEL_W'(used_len - USED_W'(1))),
    .match_next (match_next)
  );

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
      range_start    <= '0;
      range_end      <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        CFG_RANGE_START:    range_start    <= cfg_data[RANGE_W-1:0];
        CFG_RANGE_END:      range_end      <= cfg_data[RANGE_W-1:0];
        default:            ;
      endcase
    end
  end

  // scan control and window replay
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active     <= 1'b0;
      current_address <= '0;
      replay_count    <= '0;
    end else begin
      if (begin_go) begin
        scan_active     <= 1'b1;
        current_address <= low_bound;
      end else if (byte_go) begin
        if (range_done) begin
          scan_active <= 1'b0;
        end else begin
          current_address <= current_address + ADDR_BITS'(1);
        end
      end
      // Rebuild partial matches against the new entry: one full rotation.
      if (load_go & scan_active) begin
        replay_count <= CNT_W'(MAX_PATTERN);
      end else if (replay_busy) begin
        replay_count <= replay_count - CNT_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (byte_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_go) begin
      m_tdata <= {(OUT_DATA_W - OUT_ADDR_W - 1)'(0), match_address, match_next};
      m_tlast <= range_done;
    end
  end

`ifndef ASSERT_OFF
  a_replay_blocks: assert property (@(posedge clk) disable iff (rst)
    replay_busy |-> !s_tready)
    else $error("request taken during window replay");

  a_replay_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(replay_busy) |-> $past(load_go && scan_active))
    else $error("replay started without a load during a scan");

  a_byte_result: assert property (@(posedge clk) disable iff (rst)
    byte_go |=> m_tvalid)
    else $error("memory byte gave no result");

  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    (byte_go && range_done && !begin_go) |=> !scan_active)
    else $error("scan still active after last range byte");

  a_no_match_addr: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[16:1] == '0))
    else $error("address reported without a match");
`endif

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the masked byte pattern scanner: a cycle-free
// scanner model predicts one result per scanned byte, results are compared
// field by field in order, with random idle bursts on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mbps_pkg::*;

  localparam int MAX_PATTERN   = 256;
  localparam int ADDR_BITS     = 16;
  // A load inside a scan replays the window through a full rotation of the row;
  // allow it to finish before touching the registers.
  localparam int SETTLE_CYCLES = MAX_PATTERN + 8;
  localparam int RANDOM_ITEMS  = 200;
  // Request type with no meaning: the scanner must drop it.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic                  found;
    logic [OUT_ADDR_W-1:0] addr;
    logic                  done;
  } match_result_t;

  // DUT ports; every input is driven to a known value from time zero.
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [REQ_W-1:0]      s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  // Scanner model: pattern store, window (index 0 is the newest byte),
  // scan position and the three registers.
  logic [7:0]            pat_byte [MAX_PATTERN];
  bit                    pat_care [MAX_PATTERN];
  logic [7:0]            win_byte [MAX_PATTERN];
  logic [16:0]           scan_addr;
  int unsigned           scan_fill;
  bit                    scan_on;
  logic [LEN_W-1:0]      reg_length;
  logic [RANGE_W-1:0]    reg_start;
  logic [RANGE_W-1:0]    reg_end;

  match_result_t         scan_results_due [$];
  int unsigned           requests_sent = 0;
  int unsigned           mismatches    = 0;
  int unsigned           stall_left    = 0;
  bit                    idle_on       = 1'b1;

  masked_byte_pattern_scan #(
    .MAX_PATTERN(MAX_PATTERN),
    .ADDR_BITS  (ADDR_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scanner model
  // --------------------------------------------------------------------------
  function automatic logic [RANGE_W-1:0] lower_bound();
    return (reg_start < reg_end) ? reg_start : reg_end;
  endfunction

  function automatic logic [RANGE_W-1:0] upper_bound();
    return (reg_start < reg_end) ? reg_end : reg_start;
  endfunction

  // Apply one accepted request; a scanned byte queues its result.
  function automatic void advance_scanner(logic [REQ_W-1:0] kind, logic [7:0] idx,
                                          logic [7:0] val, logic care);
    match_result_t res;
    int unsigned   n;
    int            i;
    bit            hit;
    logic [16:0]   first_addr;
    case (kind)
      REQ_LOAD: begin
        pat_byte[idx] = val;
        pat_care[idx] = care;
      end
      REQ_BEGIN: begin
        scan_addr = {1'b0, lower_bound()};
        scan_fill = 0;
        foreach (win_byte[k]) win_byte[k] = 8'h00;
        scan_on = 1'b1;
      end
      REQ_BYTE: begin
        if (scan_on) begin
          for (i = MAX_PATTERN - 1; i > 0; i--) win_byte[i] = win_byte[i-1];
          win_byte[0] = val;
          if (scan_fill < MAX_PATTERN) scan_fill++;
          // Length 0 acts as 1; anything beyond the store acts as full size.
          n = (reg_length == 0) ? 1 : (reg_length > MAX_PATTERN) ? MAX_PATTERN : reg_length;
          hit = (scan_fill >= n);
          for (i = 0; i < n && hit; i++) begin
            if (pat_care[i] && win_byte[n-1-i] != pat_byte[i]) hit = 1'b0;
          end
          first_addr = scan_addr - 17'(n - 1);
          res.found  = hit;
          res.addr   = hit ? first_addr[OUT_ADDR_W-1:0] : '0;
          res.done   = (scan_addr >= {1'b0, upper_bound()});
          if (res.done) scan_on = 1'b0;
          else scan_addr = scan_addr + 17'd1;
          scan_results_due = {scan_results_due, res};
        end
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, in-order compare
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(1, 19) - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    match_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (scan_results_due.size() == 0) begin
        report_mismatch($sformatf("result with none pending: tdata=%h tlast=%b",
                                  m_tdata, m_tlast));
      end else begin
        want = scan_results_due.pop_front();
        if (m_tdata[0] !== want.found)
          report_mismatch($sformatf("match_found got %b want %b", m_tdata[0], want.found));
        if (m_tdata[OUT_ADDR_W:1] !== want.addr)
          report_mismatch($sformatf("match_address got %h want %h",
                                    m_tdata[OUT_ADDR_W:1], want.addr));
        if (m_tlast !== want.done)
          report_mismatch($sformatf("range_done got %b want %b", m_tlast, want.done));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Send one request, with an optional idle burst in front; hold until taken.
  task automatic send_request(logic [REQ_W-1:0] kind, logic [7:0] idx,
                              logic [7:0] val, logic care);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {7'd0, care, val, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_scanner(kind, idx, val, care);
    requests_sent++;
  endtask

  // Drop valid, drain every pending result, then let a possible replay end.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (scan_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only call with the scanner settled.
  task automatic write_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    case (which)
      CFG_PATTERN_LENGTH: reg_length = value[LEN_W-1:0];
      CFG_RANGE_START:    reg_start  = value[RANGE_W-1:0];
      CFG_RANGE_END:      reg_end    = value[RANGE_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Load entries 0..count-1, so no cared entry in use is ever left unwritten.
  task automatic load_pattern(int unsigned count, int unsigned care_pct);
    int unsigned i;
    for (i = 0; i < count; i++)
      send_request(REQ_LOAD, i[7:0], 8'($urandom), $urandom_range(0, 99) < care_pct);
  endtask

  // One full scan: fresh pattern, all three registers, then the whole range.
  // Copies of the pattern are planted in random bytes so matches are common;
  // a noisy scan also mixes in unused requests, live loads and at most one restart.
  task automatic scan_phase(logic [LEN_W-1:0] length_val, logic [RANGE_W-1:0] bound_a,
                            logic [RANGE_W-1:0] bound_b, int unsigned care_pct, bit noisy);
    logic [CFG_DATA_W-1:0] length_word;
    logic [7:0]            data;
    int unsigned           n;
    int unsigned           span;
    int unsigned           remaining;
    int unsigned           plant;
    bit                    restarted;
    n = (length_val == 0) ? 1 : (length_val > MAX_PATTERN) ? MAX_PATTERN : length_val;
    load_pattern(n, care_pct);
    settle();
    // Upper bits of the length word are don't-care; toggle them anyway.
    length_word = CFG_DATA_W'($urandom);
    length_word[LEN_W-1:0] = length_val;
    write_reg(CFG_PATTERN_LENGTH, length_word);
    write_reg(CFG_RANGE_START, bound_a);
    write_reg(CFG_RANGE_END, bound_b);
    span = (bound_a < bound_b) ? bound_b - bound_a + 1 : bound_a - bound_b + 1;
    send_request(REQ_BEGIN, 8'($urandom), 8'($urandom), 1'($urandom));
    remaining = span;
    plant     = n;
    restarted = 1'b0;
    while (remaining > 0) begin
      if (noisy) begin
        case ($urandom_range(0, 49))
          0: send_request(REQ_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom));
          1: send_request(REQ_LOAD, 8'($urandom), 8'($urandom), 1'($urandom));
          2: begin
            // Restart from the lower bound partway through.
            if (!restarted && remaining < span) begin
              send_request(REQ_BEGIN, 8'($urandom), 8'($urandom), 1'($urandom));
              remaining = span;
              plant     = n;
              restarted = 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (plant == n && $urandom_range(0, 2) == 0) plant = 0;
      if (plant < n) begin
        data = pat_care[plant] ? pat_byte[plant] : 8'($urandom);
        plant++;
      end else begin
        data = 8'($urandom);
      end
      send_request(REQ_BYTE, 8'($urandom), data, 1'($urandom));
      remaining--;
    end
    // A byte after the range has ended must be dropped.
    if (noisy && $urandom_range(0, 3) == 0)
      send_request(REQ_BYTE, 8'($urandom), 8'($urandom), 1'($urandom));
    settle();
  endtask

  // Mostly short patterns over short ranges, now and then at the top of the
  // address space or shorter than the pattern.
  task automatic random_phase();
    int unsigned           length_val;
    int unsigned           span;
    int unsigned           lo;
    logic [RANGE_W-1:0]    lo_addr;
    logic [RANGE_W-1:0]    hi_addr;
    case ($urandom_range(0, 9))
      0:       length_val = 0;
      1:       length_val = $urandom_range(7, 24);
      default: length_val = $urandom_range(1, 6);
    endcase
    span    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 48);
    lo      = ($urandom_range(0, 7) == 0) ? 65535 - span : $urandom_range(0, 65535 - span);
    lo_addr = lo[RANGE_W-1:0];
    hi_addr = lo_addr + span[RANGE_W-1:0];
    if ($urandom_range(0, 1) == 0) scan_phase(length_val[LEN_W-1:0], lo_addr, hi_addr, 75, 1'b1);
    else scan_phase(length_val[LEN_W-1:0], hi_addr, lo_addr, 75, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Bytes with no scan running and the unused request type give no result.
  task automatic test_ignored_requests();
    send_request(REQ_BYTE, 8'hFF, 8'hFF, 1'b1);
    send_request(REQ_UNUSED, 8'h00, 8'h00, 1'b0);
    settle();
  endtask

  // Three-byte pattern with a wildcard in the middle, bounds given swapped,
  // range ending at the last address.
  task automatic test_wildcard_match();
    logic [7:0] stream [6] = '{8'h00, 8'h5A, 8'hFF, 8'h00, 8'h00, 8'hFF};
    send_request(REQ_LOAD, 8'd0, 8'h00, 1'b1);
    send_request(REQ_LOAD, 8'd1, 8'hFF, 1'b0);
    send_request(REQ_LOAD, 8'd2, 8'hFF, 1'b1);
    settle();
    write_reg(CFG_PATTERN_LENGTH, 16'd3);
    write_reg(CFG_RANGE_START, 16'hFFFF);
    write_reg(CFG_RANGE_END, 16'hFFFA);
    send_request(REQ_BEGIN, 8'h00, 8'h00, 1'b0);
    foreach (stream[i]) send_request(REQ_BYTE, 8'h00, stream[i], 1'b0);
    // Past the end of the range: dropped.
    send_request(REQ_BYTE, 8'h00, 8'hFF, 1'b1);
    settle();
  endtask

  // Range shorter than the pattern never matches; length 0 acts as 1 and
  // a one-address range matches and ends on its only byte.
  task automatic test_short_range();
    write_reg(CFG_RANGE_START, 16'h0011);
    write_reg(CFG_RANGE_END, 16'h0010);
    send_request(REQ_BEGIN, 8'h00, 8'h00, 1'b0);
    send_request(REQ_BYTE, 8'h00, 8'h00, 1'b0);
    send_request(REQ_BYTE, 8'h00, 8'hFF, 1'b0);
    settle();
    write_reg(CFG_PATTERN_LENGTH, 16'd0);
    write_reg(CFG_RANGE_START, 16'h0000);
    write_reg(CFG_RANGE_END, 16'h0000);
    send_request(REQ_BEGIN, 8'h00, 8'h00, 1'b0);
    send_request(REQ_BYTE, 8'h00, 8'h00, 1'b0);
    settle();
  endtask

  // Restart inside a scan, load an entry while scanning, then pull the upper
  // bound behind the scan position so the next byte ends the range.
  task automatic test_restart_and_retune();
    write_reg(CFG_PATTERN_LENGTH, 16'd2);
    write_reg(CFG_RANGE_START, 16'h0100);
    write_reg(CFG_RANGE_END, 16'h0120);
    send_request(REQ_BEGIN, 8'h00, 8'h00, 1'b0);
    send_request(REQ_BYTE, 8'h00, 8'h00, 1'b0);
    send_request(REQ_BYTE, 8'h00, 8'hFF, 1'b0);
    send_request(REQ_BEGIN, 8'h00, 8'h00, 1'b0);
    send_request(REQ_BYTE, 8'h00, 8'h00, 1'b0);
    send_request(REQ_LOAD, 8'd1, 8'h33, 1'b1);
    send_request(REQ_BYTE, 8'h00, 8'h33, 1'b0);
    settle();
    write_reg(CFG_RANGE_END, 16'h0100);
    write_reg(CFG_PATTERN_LENGTH, 16'd1);
    send_request(REQ_BYTE, 8'h00, 8'h00, 1'b0);
    settle();
  endtask

  // Full-size pattern, mostly wildcards: length word above the store size,
  // then exactly the store size over a longer range.
  task automatic test_long_pattern();
    scan_phase(9'h1FF, 16'hFFFF, 16'hFF00, 10, 1'b0);
    scan_phase(9'd256, 16'h4000, 16'h412B, 10, 1'b0);
  endtask

  task automatic test_random_scans();
    int unsigned first;
    first = requests_sent;
    while (requests_sent - first < RANDOM_ITEMS) random_phase();
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_steady_stream();
    idle_on = 1'b0;
    repeat (6) random_phase();
  endtask

  initial begin
    // Model state after reset; pattern bytes are only read once loaded.
    foreach (pat_byte[i]) pat_byte[i] = 8'h00;
    foreach (pat_care[i]) pat_care[i] = 1'b1;
    foreach (win_byte[i]) win_byte[i] = 8'h00;
    scan_addr  = '0;
    scan_fill  = 0;
    scan_on    = 1'b0;
    reg_length = 9'd1;
    reg_start  = 16'h0000;
    reg_end    = 16'hFFFF;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_ignored_requests();
    test_wildcard_match();
    test_short_range();
    test_restart_and_retune();
    test_long_pattern();
    test_random_scans();
    test_steady_stream();
    if (mismatches == 0) begin
      $display("** masked_byte_pattern_scan: PASSED **");
    end else begin
      $display("** masked_byte_pattern_scan: FAILED **");
    end
    $finish;
  end

  // Hang guard, far above the slowest passing run.
  initial begin
    #2_000_000;
    $display("** masked_byte_pattern_scan: FAILED **");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_cell.sv
hw/rtl/mbps_chain.sv
hw/rtl/masked_byte_pattern_scan.sv
sim/tb_top.sv
